// ===== hw/rtl/ame_pkg.sv =====
`timescale 1ns / 1ps

package ame_pkg;

  // fixed field widths of the instruction and result transactions
  localparam int OPCODE_W   = 7;
  localparam int ADDR_W     = 7;
  localparam int IN_VALUE_W = 32;
  localparam int KIND_W     = 3;
  localparam int VALUE_W    = 32;

  localparam int MEMORY_WORDS_DEF = 128;
  localparam int WORD_BITS_DEF    = 32;

  localparam logic [OPCODE_W-1:0] OP_INPUT     = 7'd10;
  localparam logic [OPCODE_W-1:0] OP_OUTPUT    = 7'd11;
  localparam logic [OPCODE_W-1:0] OP_LOAD      = 7'd20;
  localparam logic [OPCODE_W-1:0] OP_STORE     = 7'd21;
  localparam logic [OPCODE_W-1:0] OP_ADD       = 7'd30;
  localparam logic [OPCODE_W-1:0] OP_SUB       = 7'd31;
  localparam logic [OPCODE_W-1:0] OP_DIV       = 7'd32;
  localparam logic [OPCODE_W-1:0] OP_GOTO      = 7'd40;
  localparam logic [OPCODE_W-1:0] OP_NEG_GOTO  = 7'd41;
  localparam logic [OPCODE_W-1:0] OP_ZERO_GOTO = 7'd42;
  localparam logic [OPCODE_W-1:0] OP_HALT      = 7'd43;

  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OUTPUT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_JUMP    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HALT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIVZERO = 3'd4;

  typedef struct packed {
    logic latch_in;
    logic mem_read;
    logic execute;
    logic clear_step;
    logic load_out;
  } ame_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_run;
    logic div_done;
  } ame_status_t;

endpackage

// ===== hw/rtl/accumulator_machine_execute.sv =====
`timescale 1ns / 1ps
// an accepted instruction passes READ, EXEC and WAIT before its result is loaded into the
// output register; DIV with a non-zero divisor adds the DIV state, run by the serial divider
// no new instruction is accepted until the result of the last one has been loaded
// a finished result waits in the output register while the next instruction is accepted
// reset: accumulator cleared at once; a clearing pass zeroes the data memory word by word,
// during which no instruction is accepted

module accumulator_machine_execute import ame_pkg::*; #(
  parameter int MEMORY_WORDS = MEMORY_WORDS_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [OPCODE_W-1:0]          opcode,
  input  logic [ADDR_W-1:0]            address,
  input  logic signed [IN_VALUE_W-1:0] input_value,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [KIND_W-1:0]            kind,
  output logic signed [VALUE_W-1:0]    value,
  output logic [ADDR_W-1:0]            jump_target
);

  ame_cmd_t    cmd;
  ame_status_t status;

  ame_controller u_controller (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  ame_datapath #(
    .MEMORY_WORDS (MEMORY_WORDS),
    .WORD_BITS    (WORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .opcode      (opcode),
    .address     (address),
    .input_value (input_value),
    .kind        (kind),
    .value       (value),
    .jump_target (jump_target)
  );

  // one instruction in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("second transaction taken while one is in flight");

  // a result still waiting is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result_valid || result_ready))
    else $error("result register loaded while holding an untaken result");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.latch_in, cmd.mem_read, cmd.execute, cmd.clear_step, cmd.load_out}))
    else $error("controller issued more than one command");

  // a taken jump is the only result that carries a target
  a_target_only_on_jump: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind != KIND_JUMP) |-> (jump_target == '0))
    else $error("jump target set on a result that is not a jump");

endmodule

// ===== hw/rtl/ame_divider.sv =====
`timescale 1ns / 1ps

module ame_divider import ame_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 done,
  output logic [WORD_BITS-1:0] quotient
);

  localparam int CW = $clog2(WORD_BITS + 1);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] dvs;
  logic                 neg;
  logic [WORD_BITS-1:0] mag_a;
  logic [WORD_BITS-1:0] mag_b;
  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   trial;

  // magnitudes of the signed operands; the most negative value fits unsigned
  assign mag_a = dividend[WORD_BITS-1] ? -dividend : dividend;
  assign mag_b = divisor[WORD_BITS-1] ? -divisor : divisor;

  assign shifted = {rem, quo[WORD_BITS-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WORD_BITS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= mag_a;
      dvs <= mag_b;
      neg <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
    end else if (busy) begin
      if (!trial[WORD_BITS]) begin
        rem <= trial[WORD_BITS-1:0];
        quo <= {quo[WORD_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[WORD_BITS-1:0];
        quo <= {quo[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -quo : quo;

endmodule

// ===== hw/rtl/ame_datapath.sv =====
`timescale 1ns / 1ps

module ame_datapath import ame_pkg::*; #(
  parameter int MEMORY_WORDS = MEMORY_WORDS_DEF,
  parameter int WORD_BITS    = WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ame_cmd_t                     cmd,
  output ame_status_t                  status,
  input  logic [OPCODE_W-1:0]          opcode,
  input  logic [ADDR_W-1:0]            address,
  input  logic signed [IN_VALUE_W-1:0] input_value,
  output logic [KIND_W-1:0]            kind,
  output logic signed [VALUE_W-1:0]    value,
  output logic [ADDR_W-1:0]            jump_target
);

  localparam int IW = $clog2(MEMORY_WORDS);
  localparam int RW = (IW + 1 > ADDR_W) ? IW + 1 : ADDR_W;

  logic [OPCODE_W-1:0]   op_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [WORD_BITS-1:0]  in_word;
  logic [WORD_BITS-1:0]  acc;
  logic [WORD_BITS-1:0]  mem [MEMORY_WORDS];
  logic [WORD_BITS-1:0]  mem_rdata;
  logic [IW-1:0]         clr_cnt;
  logic [RW-1:0]         red;
  logic [IW-1:0]         idx;
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic                  div_start;
  logic                  div_done;
  logic [WORD_BITS-1:0]  div_quotient;
  logic [KIND_W-1:0]     kind_c;
  logic [VALUE_W-1:0]    value_c;
  logic [ADDR_W-1:0]     target_c;
  logic [KIND_W-1:0]     pend_kind;
  logic [VALUE_W-1:0]    pend_value;
  logic [ADDR_W-1:0]     pend_target;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q    <= opcode;
      addr_q  <= address;
      in_word <= WORD_BITS'(input_value);
    end
  end

  // address modulo memory depth by up to eight subtractions, exact while the depth is at least 15
  always_comb begin
    red = RW'(addr_q);
    for (int i = 0; i < 8; i++) begin
      if (red >= RW'(MEMORY_WORDS)) begin
        red = red - RW'(MEMORY_WORDS);
      end
    end
    idx = red[IW-1:0];
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + IW'(1);
    end
  end

  assign status.clear_last = (clr_cnt == IW'(MEMORY_WORDS - 1));

  always_comb begin
    mem_we    = cmd.clear_step ||
                (cmd.execute && (op_q == OP_INPUT || op_q == OP_STORE));
    mem_waddr = cmd.clear_step ? clr_cnt : idx;
    if (cmd.clear_step) begin
      mem_wdata = '0;
    end else if (op_q == OP_INPUT) begin
      mem_wdata = in_word;
    end else begin
      mem_wdata = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.mem_read) begin
      mem_rdata <= mem[idx];
    end
  end

  assign div_start      = cmd.execute && (op_q == OP_DIV) && (mem_rdata != '0);
  assign status.div_run = (op_q == OP_DIV) && (mem_rdata != '0);
  assign status.div_done = div_done;

  ame_divider #(
    .WORD_BITS (WORD_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (mem_rdata),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.execute) begin
      case (op_q)
        OP_LOAD: acc <= mem_rdata;
        OP_ADD:  acc <= acc + mem_rdata;
        OP_SUB:  acc <= acc - mem_rdata;
        default: ;
      endcase
    end else if (div_done) begin
      acc <= div_quotient;
    end
  end

  always_comb begin
    kind_c   = KIND_NONE;
    value_c  = '0;
    target_c = '0;
    unique case (op_q)
      OP_OUTPUT: begin
        kind_c  = KIND_OUTPUT;
        value_c = VALUE_W'(acc);
      end
      OP_DIV: begin
        if (mem_rdata == '0) begin
          kind_c = KIND_DIVZERO;
        end
      end
      OP_GOTO: begin
        kind_c   = KIND_JUMP;
        target_c = addr_q;
      end
      OP_NEG_GOTO: begin
        if (acc[WORD_BITS-1]) begin
          kind_c   = KIND_JUMP;
          target_c = addr_q;
        end
      end
      OP_ZERO_GOTO: begin
        if (acc == '0) begin
          kind_c   = KIND_JUMP;
          target_c = addr_q;
        end
      end
      OP_HALT: kind_c = KIND_HALT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      pend_kind   <= kind_c;
      pend_value  <= value_c;
      pend_target <= target_c;
    end
    if (cmd.load_out) begin
      kind        <= pend_kind;
      value       <= pend_value;
      jump_target <= pend_target;
    end
  end

endmodule

// ===== hw/rtl/ame_controller.sv =====
`timescale 1ns / 1ps

module ame_controller import ame_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  output logic        result_valid,
  input  logic        result_ready,
  input  ame_status_t status,
  output ame_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_DIV   = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_EXEC;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = status.div_run ? S_DIV : S_WAIT;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        // output register free or being emptied this cycle
        if (!result_valid || result_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
